/* rtl/nmea_sentence_deframer_top_macros.svh */
// assertion macros shared by the nmea sentence deframer rtl
`ifndef NMEA_SENTENCE_DEFRAMER_TOP_MACROS_SVH
`define NMEA_SENTENCE_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define NSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define NSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define NSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/nmea_sd_pkg.sv */
// shared constants and result type of the nmea sentence deframer
`timescale 1ns / 1ps
package nmea_sd_pkg;

  // field limit and derived widths
  localparam int MAX_FIELDS = 31;
  localparam int FIELD_W    = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
  localparam int CNT_W      = $clog2(MAX_FIELDS + 1);

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // result kinds
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // one result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] field_char;
    logic [4:0] field_index;
    logic       sentence_valid;
    logic       checksum_present;
    logic       checksum_match;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [4:0] field_count;
  } res_t;

endpackage

/* rtl/nmea_sd_core.sv */
// sentence state and per-byte result logic of the nmea deframer
`timescale 1ns / 1ps
`include "nmea_sentence_deframer_top_macros.svh"
module nmea_sd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output nmea_sd_pkg::res_t res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HEX  = 2'd2;
  localparam logic [1:0] PH_TAIL = 2'd3;

  localparam int FW = nmea_sd_pkg::FIELD_W;
  localparam int CW = nmea_sd_pkg::CNT_W;
  localparam logic [FW-1:0] FIELD_LAST = FW'(nmea_sd_pkg::MAX_FIELDS - 1);
  localparam logic [CW-1:0] CNT_MAX    = CW'(nmea_sd_pkg::MAX_FIELDS);

  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [7:0]    hex_r, hex_nxt;
  logic          hex_seen_r, hex_seen_nxt;
  logic [FW-1:0] field_r, field_nxt;
  logic          name_nz_r, name_nz_nxt;
  logic          chars_ok_r, chars_ok_nxt;
  logic          last_comma_r, last_comma_nxt;
  logic          star_r, star_nxt;

  logic          is_ws;
  logic          is_alnum;
  logic          is_hex;
  logic [3:0]    hex_digit;
  logic [CW-1:0] count;

  // character classes
  always_comb begin
    is_ws = (rx_byte == nmea_sd_pkg::CH_TAB) || (rx_byte == nmea_sd_pkg::CH_SPACE) ||
            (rx_byte == nmea_sd_pkg::CH_CR);
    is_alnum = (rx_byte >= 8'h30 && rx_byte <= 8'h39) ||
               (rx_byte >= 8'h41 && rx_byte <= 8'h5A) ||
               (rx_byte >= 8'h61 && rx_byte <= 8'h7A);
    is_hex    = 1'b1;
    hex_digit = 4'd0;
    priority if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      hex_digit = rx_byte[3:0];
    end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
                 (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
      hex_digit = rx_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // saturating field count
  always_comb begin
    count = CW'(field_r) + CW'(1);
    if (count > CNT_MAX) begin
      count = CNT_MAX;
    end
  end

  // next state and result for this byte
  always_comb begin
    phase_nxt      = phase_r;
    xor_nxt        = xor_r;
    hex_nxt        = hex_r;
    hex_seen_nxt   = hex_seen_r;
    field_nxt      = field_r;
    name_nz_nxt    = name_nz_r;
    chars_ok_nxt   = chars_ok_r;
    last_comma_nxt = last_comma_r;
    star_nxt       = star_r;
    res_valid      = 1'b0;
    res            = '0;
    priority if (is_ws) begin
      // whitespace dropped everywhere
    end else if (rx_byte == nmea_sd_pkg::CH_DOLLAR) begin
      phase_nxt      = PH_BODY;
      xor_nxt        = 8'd0;
      hex_nxt        = 8'd0;
      hex_seen_nxt   = 1'b0;
      field_nxt      = '0;
      name_nz_nxt    = 1'b0;
      chars_ok_nxt   = 1'b1;
      last_comma_nxt = 1'b0;
      star_nxt       = 1'b0;
    end else if (phase_r == PH_IDLE) begin
      // outside a sentence
    end else if (rx_byte == nmea_sd_pkg::CH_LF) begin
      res_valid              = 1'b1;
      res.kind               = nmea_sd_pkg::KIND_STATUS;
      res.sentence_valid     = name_nz_r && chars_ok_r;
      res.checksum_present   = hex_seen_r;
      res.checksum_match     = hex_seen_r && (hex_r == xor_r);
      res.computed_checksum  = xor_r;
      res.received_checksum  = hex_r;
      res.field_count        = 5'(count);
      phase_nxt              = PH_IDLE;
    end else if (phase_r == PH_HEX && is_hex) begin
      hex_nxt      = {hex_r[3:0], hex_digit};
      hex_seen_nxt = 1'b1;
    end else if (phase_r == PH_HEX || phase_r == PH_TAIL) begin
      phase_nxt      = PH_TAIL;
      chars_ok_nxt   = 1'b0;
      last_comma_nxt = (rx_byte == nmea_sd_pkg::CH_COMMA);
    end else if (rx_byte == nmea_sd_pkg::CH_STAR) begin
      star_nxt  = 1'b1;
      phase_nxt = PH_HEX;
    end else if (rx_byte == nmea_sd_pkg::CH_COMMA) begin
      xor_nxt        = xor_r ^ rx_byte;
      last_comma_nxt = 1'b1;
      if (field_r < FIELD_LAST) begin
        field_nxt = field_r + FW'(1);
      end
    end else begin
      xor_nxt        = xor_r ^ rx_byte;
      last_comma_nxt = 1'b0;
      if (field_r == '0) begin
        name_nz_nxt = 1'b1;
        if (!is_alnum) begin
          chars_ok_nxt = 1'b0;
        end
      end else if (!is_alnum && rx_byte != nmea_sd_pkg::CH_DASH &&
                   rx_byte != nmea_sd_pkg::CH_DOT) begin
        chars_ok_nxt = 1'b0;
      end
      res_valid       = 1'b1;
      res.kind        = nmea_sd_pkg::KIND_CHAR;
      res.field_char  = rx_byte;
      res.field_index = 5'(field_r);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      xor_r        <= 8'd0;
      hex_r        <= 8'd0;
      hex_seen_r   <= 1'b0;
      field_r      <= '0;
      name_nz_r    <= 1'b0;
      chars_ok_r   <= 1'b1;
      last_comma_r <= 1'b0;
      star_r       <= 1'b0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      xor_r        <= xor_nxt;
      hex_r        <= hex_nxt;
      hex_seen_r   <= hex_seen_nxt;
      field_r      <= field_nxt;
      name_nz_r    <= name_nz_nxt;
      chars_ok_r   <= chars_ok_nxt;
      last_comma_r <= last_comma_nxt;
      star_r       <= star_nxt;
    end
  end

  // checks
  `NSD_ASSERT_NEXT(a_status_ends_sentence, clk, rst_n,
    acc && res_valid && res.kind == nmea_sd_pkg::KIND_STATUS, phase_r == PH_IDLE,
    "status beat did not return to idle")
  `NSD_ASSERT_NOW(a_hex_needs_star, clk, rst_n, hex_seen_r, star_r,
    "checksum digits seen without star")
  `NSD_ASSERT_NOW(a_field_saturates, clk, rst_n, 1'b1, field_r <= FIELD_LAST,
    "field index beyond the last field")

endmodule

/* rtl/nmea_sentence_deframer_top.sv */
// top level of the nmea sentence deframer: core plus output and skid registers
//
// Input channel in_valid/in_stall/in_rx_byte carries one stream byte per beat.
// Output channel out_valid/out_stall carries one result beat per field byte
// (out_kind 0, with out_field_char and out_field_index) or one status beat on
// line feed (out_kind 1, with validity, checksum and field count fields).
// Whitespace, bytes outside a sentence, '$', ',' and checksum bytes give no
// output beat.
// Each result is registered in the output register, or in the skid register.
// Throughput: one byte per cycle while the skid register is empty; the core
// updates its sentence state on each byte taken.
// When the receiver stalls, the output register holds its beat and one more
// result goes into the skid register; in_stall is then raised until the skid
// drains. in_stall depends only on registered state.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle, waiting for '$'.
`timescale 1ns / 1ps
`include "nmea_sentence_deframer_top_macros.svh"
module nmea_sentence_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_field_char,
  output logic [4:0] out_field_index,
  output logic       out_sentence_valid,
  output logic       out_checksum_present,
  output logic       out_checksum_match,
  output logic [7:0] out_computed_checksum,
  output logic [7:0] out_received_checksum,
  output logic [4:0] out_field_count
);

  logic              in_acc;
  logic              res_valid;
  nmea_sd_pkg::res_t res;
  logic              push;
  logic              take;
  logic              out_v_r;
  logic              skid_v_r;
  nmea_sd_pkg::res_t out_r;
  nmea_sd_pkg::res_t skid_r;

  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;
  assign push     = in_acc && res_valid;
  assign take     = !out_v_r || !out_stall;

  nmea_sd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // output and skid valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= push;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_v_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid             = out_v_r;
  assign out_kind              = out_r.kind;
  assign out_field_char        = out_r.field_char;
  assign out_field_index       = out_r.field_index;
  assign out_sentence_valid    = out_r.sentence_valid;
  assign out_checksum_present  = out_r.checksum_present;
  assign out_checksum_match    = out_r.checksum_match;
  assign out_computed_checksum = out_r.computed_checksum;
  assign out_received_checksum = out_r.received_checksum;
  assign out_field_count       = out_r.field_count;

  // checks
  `NSD_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r,
    "skid holds a beat while output is empty")
  `NSD_ASSERT_NEXT(a_stalled_push_skids, clk, rst_n,
    push && out_v_r && out_stall, skid_v_r,
    "result lost while output stalled")
  `NSD_ASSERT_NOW(a_status_no_char, clk, rst_n,
    out_v_r && out_kind == nmea_sd_pkg::KIND_STATUS,
    out_field_char == 8'd0 && out_field_index == 5'd0,
    "status beat carries field character data")

endmodule

/* tb/testbench.sv */
// self-checking testbench for the nmea sentence deframer top level
`timescale 1ns / 1ps
module testbench;

  // parser phases of the line model
  localparam logic [1:0] PS_IDLE = 2'd0;
  localparam logic [1:0] PS_BODY = 2'd1;
  localparam logic [1:0] PS_HEX  = 2'd2;
  localparam logic [1:0] PS_TAIL = 2'd3;

  // one row of the directed script
  typedef struct {
    logic [7:0]        ch;
    bit                typed;
    nmea_sd_pkg::res_t want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_field_char;
  logic [4:0] out_field_index;
  logic       out_sentence_valid;
  logic       out_checksum_present;
  logic       out_checksum_match;
  logic [7:0] out_computed_checksum;
  logic [7:0] out_received_checksum;
  logic [4:0] out_field_count;

  // line model state
  logic [1:0]   ph = PS_IDLE;
  logic [7:0]   sum_x = 8'h00;
  logic [7:0]   hex_acc = 8'h00;
  bit           hex_any = 1'b0;
  int           fld_no = 0;
  bit           name_nz = 1'b0;
  bit           chars_good = 1'b1;

  nmea_sd_pkg::res_t pending_q[$];
  nmea_sd_pkg::res_t seen_beat;
  script_row_t       script[$];
  int                mism = 0;
  int                work_bytes = 0;
  int                tx_calm = 0;
  logic [7:0]        blanks[3] = '{nmea_sd_pkg::CH_TAB, nmea_sd_pkg::CH_SPACE,
                                   nmea_sd_pkg::CH_CR};

  nmea_sentence_deframer_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_field_char       (out_field_char),
    .out_field_index      (out_field_index),
    .out_sentence_valid   (out_sentence_valid),
    .out_checksum_present (out_checksum_present),
    .out_checksum_match   (out_checksum_match),
    .out_computed_checksum(out_computed_checksum),
    .out_received_checksum(out_received_checksum),
    .out_field_count      (out_field_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // typed status beat for the directed rows
  function automatic nmea_sd_pkg::res_t status_beat(bit v, bit p, bit m, logic [7:0] cs,
                                                    logic [7:0] rc, logic [4:0] n);
    nmea_sd_pkg::res_t r = '0;
    r.kind = nmea_sd_pkg::KIND_STATUS;
    r.sentence_valid = v;
    r.checksum_present = p;
    r.checksum_match = m;
    r.computed_checksum = cs;
    r.received_checksum = rc;
    r.field_count = n;
    return r;
  endfunction

  // typed field character beat for the directed rows
  function automatic nmea_sd_pkg::res_t char_beat(logic [7:0] c, logic [4:0] idx);
    nmea_sd_pkg::res_t r = '0;
    r.kind = nmea_sd_pkg::KIND_CHAR;
    r.field_char = c;
    r.field_index = idx;
    return r;
  endfunction

  // append one row to the directed script
  function automatic void add_row(logic [7:0] ch, bit typed, nmea_sd_pkg::res_t want);
    script_row_t row;
    row.ch = ch;
    row.typed = typed;
    row.want = want;
    script.insert(script.size(), row);
  endfunction

  // advance the line model by one byte; got marks a result beat
  function automatic void parse_byte(input logic [7:0] c, output bit used, output bit got,
                                     output nmea_sd_pkg::res_t r);
    int  dv;
    int  cnt;
    bit  alnum_c;
    used = 1'b0;
    got = 1'b0;
    r = '0;
    dv = -1;
    alnum_c = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    if (c == nmea_sd_pkg::CH_TAB || c == nmea_sd_pkg::CH_SPACE ||
        c == nmea_sd_pkg::CH_CR) return;
    if (c == nmea_sd_pkg::CH_DOLLAR) begin
      used = 1'b1;
      ph = PS_BODY;
      sum_x = 8'h00;
      hex_acc = 8'h00;
      hex_any = 1'b0;
      fld_no = 0;
      name_nz = 1'b0;
      chars_good = 1'b1;
      return;
    end
    if (ph == PS_IDLE) return;
    used = 1'b1;
    // line feed closes the sentence with a status beat
    if (c == nmea_sd_pkg::CH_LF) begin
      cnt = fld_no + 1;
      if (cnt > nmea_sd_pkg::MAX_FIELDS) cnt = nmea_sd_pkg::MAX_FIELDS;
      r.kind = nmea_sd_pkg::KIND_STATUS;
      r.sentence_valid = name_nz && chars_good;
      r.checksum_present = hex_any;
      r.checksum_match = hex_any && (hex_acc == sum_x);
      r.computed_checksum = sum_x;
      r.received_checksum = hex_acc;
      r.field_count = cnt[4:0];
      ph = PS_IDLE;
      got = 1'b1;
      return;
    end
    // checksum text: hex digits only, anything else spoils the sentence
    if (ph == PS_HEX || ph == PS_TAIL) begin
      if (c >= "0" && c <= "9") dv = c - "0";
      else if (c >= "A" && c <= "F") dv = c - "A" + 10;
      else if (c >= "a" && c <= "f") dv = c - "a" + 10;
      if (ph == PS_HEX && dv >= 0) begin
        hex_acc = {hex_acc[3:0], dv[3:0]};
        hex_any = 1'b1;
        return;
      end
      ph = PS_TAIL;
      chars_good = 1'b0;
      return;
    end
    if (c == nmea_sd_pkg::CH_STAR) begin
      ph = PS_HEX;
      return;
    end
    // body byte: xor, split on comma, check the field's character rule
    sum_x = sum_x ^ c;
    if (c == nmea_sd_pkg::CH_COMMA) begin
      if (fld_no < nmea_sd_pkg::MAX_FIELDS - 1) fld_no++;
      return;
    end
    if (fld_no == 0) begin
      name_nz = 1'b1;
      if (!alnum_c) chars_good = 1'b0;
    end else if (!alnum_c && c != nmea_sd_pkg::CH_DASH && c != nmea_sd_pkg::CH_DOT) begin
      chars_good = 1'b0;
    end
    r.kind = nmea_sd_pkg::KIND_CHAR;
    r.field_char = c;
    r.field_index = fld_no[4:0];
    got = 1'b1;
  endfunction

  function automatic void check_field(string nm, logic [7:0] want, logic [7:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", nm, want, seen);
      mism++;
    end
  endfunction

  // offer one byte after a random gap and log what the model expects from it
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input nmea_sd_pkg::res_t want);
    int                gap;
    bit                used;
    bit                got;
    nmea_sd_pkg::res_t beat;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      tx_calm = 24;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    parse_byte(b, used, got, beat);
    if (used) work_bytes++;
    if (typed) pending_q.insert(pending_q.size(), want);
    else if (got) pending_q.insert(pending_q.size(), beat);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d char %0h", out_kind,
               out_field_char);
        mism++;
      end else begin
        seen_beat = pending_q.pop_front();
        check_field("kind", seen_beat.kind, out_kind);
        check_field("field_char", seen_beat.field_char, out_field_char);
        check_field("field_index", seen_beat.field_index, out_field_index);
        check_field("sentence_valid", seen_beat.sentence_valid, out_sentence_valid);
        check_field("checksum_present", seen_beat.checksum_present, out_checksum_present);
        check_field("checksum_match", seen_beat.checksum_match, out_checksum_match);
        check_field("computed_checksum", seen_beat.computed_checksum, out_computed_checksum);
        check_field("received_checksum", seen_beat.received_checksum, out_received_checksum);
        check_field("field_count", seen_beat.field_count, out_field_count);
      end
    end
  end

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int hold;
    int rx_taken;
    int rx_calm;
    rx_taken = 0;
    rx_calm = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_taken == 30) begin
        hold = 90;
      end else if (rx_calm > 0) begin
        rx_calm--;
        hold = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        rx_calm = 20;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      rx_taken++;
    end
  end

  // stimulus: reset, directed script, then random sentences
  initial begin
    logic [7:0] line_q[$];
    logic [7:0] xs;
    logic [7:0] c;
    int         sel;
    int         nlen;
    int         nparams;
    int         ck;
    string      alnum;
    string      hx;
    string      anyhex;
    string      tails;
    alnum = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    anyhex = "0123456789ABCDEFabcdef";
    tails = ",*G!";

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // stray line feed, non-printing bytes in a parameter
    add_row(nmea_sd_pkg::CH_LF, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_DOLLAR, 1'b0, '0);
    add_row("A", 1'b1, char_beat("A", 5'd0));
    add_row(nmea_sd_pkg::CH_SPACE, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_COMMA, 1'b0, '0);
    add_row(8'h00, 1'b1, char_beat(8'h00, 5'd1));
    add_row(8'hFF, 1'b1, char_beat(8'hFF, 5'd1));
    add_row(nmea_sd_pkg::CH_LF, 1'b1, status_beat(0, 0, 0, 8'h92, 8'h00, 5'd2));
    // dash and dot, trailing comma, star with no digits
    add_row(nmea_sd_pkg::CH_DOLLAR, 1'b0, '0);
    add_row("Z", 1'b0, '0);
    add_row("9", 1'b0, '0);
    add_row(nmea_sd_pkg::CH_COMMA, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_DASH, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_DOT, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_COMMA, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_STAR, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_CR, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_LF, 1'b1, status_beat(1, 0, 0, 8'h60, 8'h00, 5'd3));
    // restart, name only with a matching checksum
    add_row(nmea_sd_pkg::CH_DOLLAR, 1'b0, '0);
    add_row(nmea_sd_pkg::CH_DOLLAR, 1'b0, '0);
    add_row("a", 1'b0, '0);
    add_row(nmea_sd_pkg::CH_STAR, 1'b0, '0);
    add_row("6", 1'b0, '0);
    add_row("1", 1'b0, '0);
    add_row(nmea_sd_pkg::CH_LF, 1'b1, status_beat(1, 1, 1, 8'h61, 8'h61, 5'd1));
    foreach (script[i]) send_byte(script[i].ch, script[i].typed, script[i].want);

    // random sentences with some noise and broken lines
    while (work_bytes < 750) begin
      line_q.delete();
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        repeat ($urandom_range(1, 12)) line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
      end else begin
        line_q.insert(line_q.size(), nmea_sd_pkg::CH_DOLLAR);
        xs = 8'h00;
        nlen = $urandom_range(0, 6);
        nparams = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        // sentence name
        repeat (nlen) begin
          c = alnum[$urandom_range(0, 61)];
          if ($urandom_range(0, 29) == 0) c = 8'($urandom_range(0, 255));
          line_q.insert(line_q.size(), c);
          xs = xs ^ c;
        end
        // parameters
        repeat (nparams) begin
          line_q.insert(line_q.size(), nmea_sd_pkg::CH_COMMA);
          xs = xs ^ nmea_sd_pkg::CH_COMMA;
          repeat ($urandom_range(0, 5)) begin
            c = alnum[$urandom_range(0, 61)];
            if ($urandom_range(0, 7) == 0) begin
              c = $urandom_range(0, 1) ? nmea_sd_pkg::CH_DASH : nmea_sd_pkg::CH_DOT;
            end
            if ($urandom_range(0, 39) == 0) c = 8'($urandom_range(0, 255));
            line_q.insert(line_q.size(), c);
            xs = xs ^ c;
          end
        end
        if (sel == 1) begin
          line_q.insert(line_q.size(), nmea_sd_pkg::CH_COMMA);
          xs = xs ^ nmea_sd_pkg::CH_COMMA;
        end
        // checksum text: none, empty, correct, or random digits
        ck = $urandom_range(0, 9);
        if (ck >= 2) begin
          line_q.insert(line_q.size(), nmea_sd_pkg::CH_STAR);
          if (ck >= 3 && ck <= 8) begin
            hx = $urandom_range(0, 1) ? "0123456789ABCDEF" : "0123456789abcdef";
            line_q.insert(line_q.size(), hx[xs[7:4]]);
            line_q.insert(line_q.size(), hx[xs[3:0]]);
          end else if (ck == 9) begin
            repeat ($urandom_range(1, 4)) begin
              line_q.insert(line_q.size(), anyhex[$urandom_range(0, 21)]);
            end
          end
          if ($urandom_range(0, 9) == 0) begin
            line_q.insert(line_q.size(), tails[$urandom_range(0, 3)]);
          end
        end
        if ($urandom_range(0, 1) == 0) line_q.insert(line_q.size(), nmea_sd_pkg::CH_CR);
        if ($urandom_range(0, 24) != 0) line_q.insert(line_q.size(), nmea_sd_pkg::CH_LF);
      end
      foreach (line_q[i]) begin
        if ($urandom_range(0, 24) == 0) send_byte(blanks[$urandom_range(0, 2)], 1'b0, '0);
        send_byte(line_q[i], 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain, then wait for stray beats
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mism == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/nmea_sd_pkg.sv
rtl/nmea_sd_core.sv
rtl/nmea_sentence_deframer_top.sv
tb/testbench.sv
